>>> src/asg_pkg.sv
// shared types, constants and cosine table math for the asymmetric sine generator
package asg_pkg;

    localparam int SINE_DEPTH_DEFAULT = 256;

    localparam int TIME_W   = 32;
    localparam int FREQ_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int LEVEL_W  = 16;
    localparam int PHASE_W  = 32;
    localparam int VALUE_W  = 17;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PHASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASYMMETRY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd4;

    localparam logic [FREQ_W-1:0]         FREQUENCY_RESET = 24'd65536;
    localparam logic signed [LEVEL_W-1:0] MAX_LEVEL_RESET = 16'sd256;

    localparam logic [VALUE_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;

    localparam int DIV_QUOT_W          = 33;
    localparam int DIV_REM_W           = 16;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = (DIV_QUOT_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    typedef struct packed {
        logic [FREQ_W-1:0]         frequency;
        logic [FRAC_W-1:0]         offset_phase;
        logic [FRAC_W-1:0]         asymmetry;
        logic signed [LEVEL_W-1:0] min_level;
        logic signed [LEVEL_W-1:0] max_level;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic                  hold;
        logic [DIV_QUOT_W-1:0] quot;
    } t_div_beat;

    typedef struct packed {
        logic               valid;
        logic               hold;
        logic [VALUE_W-1:0] level_v;
    } t_cos_beat;

    // cos(x) in Q1.16 from x in Q2.30, truncating taylor series in Q2.30
    function automatic logic [VALUE_W-1:0] cos_q16(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        rounded = ($unsigned(sum) + 64'd8192) >> 14;
        return rounded[VALUE_W-1:0];
    endfunction

    // table entry, padded with zero past the last point
    function automatic logic [VALUE_W-1:0] cos_rom_entry(input int idx, input int depth,
                                                         input logic [63:0] x);
        logic [VALUE_W-1:0] entry;
        if (idx == 0) begin
            entry = ONE_Q16;
        end else if (idx >= depth) begin
            entry = '0;
        end else begin
            entry = cos_q16(x);
        end
        return entry;
    endfunction

endpackage

>>> src/asg_cfg_regs.sv
// apb configuration registers of the asymmetric sine generator
module asg_cfg_regs import asg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_IDX_W-1:0] w_index;
    logic                 w_write;
    t_cfg                 r_cfg;

    assign w_index = paddr[CFG_ADDR_W-1:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frequency    <= FREQUENCY_RESET;
            r_cfg.offset_phase <= '0;
            r_cfg.asymmetry    <= '0;
            r_cfg.min_level    <= '0;
            r_cfg.max_level    <= MAX_LEVEL_RESET;
        end else if (w_write) begin
            case (w_index)
                REG_FREQUENCY:    r_cfg.frequency    <= pwdata[FREQ_W-1:0];
                REG_OFFSET_PHASE: r_cfg.offset_phase <= pwdata[FRAC_W-1:0];
                REG_ASYMMETRY:    r_cfg.asymmetry    <= pwdata[FRAC_W-1:0];
                REG_MIN_LEVEL:    r_cfg.min_level    <= $signed(pwdata[LEVEL_W-1:0]);
                REG_MAX_LEVEL:    r_cfg.max_level    <= $signed(pwdata[LEVEL_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_FREQUENCY:    prdata = APB_DATA_W'(r_cfg.frequency);
            REG_OFFSET_PHASE: prdata = APB_DATA_W'(r_cfg.offset_phase);
            REG_ASYMMETRY:    prdata = APB_DATA_W'(r_cfg.asymmetry);
            REG_MIN_LEVEL:    prdata = APB_DATA_W'($unsigned(r_cfg.min_level));
            REG_MAX_LEVEL:    prdata = APB_DATA_W'($unsigned(r_cfg.max_level));
            default:          prdata = '0;
        endcase
    end

endmodule

>>> src/asg_divider.sv
// pipelined restoring divider: stretched phase = (phase << 16) / (1 - asymmetry)
module asg_divider import asg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [FRAC_W-1:0]  i_asymmetry,
    output t_div_beat          o_beat
);

    logic [DIV_REM_W:0] w_inv;
    logic               w_hold;

    logic                  r_valid [DIV_STAGES];
    logic                  r_hold  [DIV_STAGES];
    logic [DIV_REM_W-1:0]  r_rem   [DIV_STAGES];
    logic [DIV_QUOT_W-1:0] r_quot  [DIV_STAGES];
    logic [DIV_QUOT_W-1:0] r_bits  [DIV_STAGES];
    logic [DIV_REM_W-1:0]  n_rem   [DIV_STAGES];
    logic [DIV_QUOT_W-1:0] n_quot  [DIV_STAGES];
    logic [DIV_QUOT_W-1:0] n_bits  [DIV_STAGES];

    assign w_inv  = ONE_Q16 - {1'b0, i_asymmetry};
    assign w_hold = {1'b0, i_phase} > {w_inv, 16'h0000};

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic                  s_valid;
        logic                  s_hold;
        logic [DIV_REM_W-1:0]  s_rem;
        logic [DIV_QUOT_W-1:0] s_quot;
        logic [DIV_QUOT_W-1:0] s_bits;

        if (g == 0) begin : g_first
            // quotient never reaches bit 33, so the top phase bits start as remainder
            assign s_valid = i_valid;
            assign s_hold  = w_hold;
            assign s_rem   = {1'b0, i_phase[PHASE_W-1:17]};
            assign s_quot  = '0;
            assign s_bits  = {i_phase[16:0], 16'h0000};
        end else begin : g_next
            assign s_valid = r_valid[g-1];
            assign s_hold  = r_hold[g-1];
            assign s_rem   = r_rem[g-1];
            assign s_quot  = r_quot[g-1];
            assign s_bits  = r_bits[g-1];
        end

        always_comb begin : p_steps
            logic [DIV_REM_W:0]    shifted;
            logic [DIV_REM_W-1:0]  rem_v;
            logic [DIV_QUOT_W-1:0] quot_v;
            logic [DIV_QUOT_W-1:0] bits_v;
            shifted = '0;
            rem_v   = s_rem;
            quot_v  = s_quot;
            bits_v  = s_bits;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                if (g * DIV_STEPS_PER_STAGE + j < DIV_QUOT_W) begin
                    shifted = {rem_v, bits_v[DIV_QUOT_W-1]};
                    bits_v  = {bits_v[DIV_QUOT_W-2:0], 1'b0};
                    if (shifted >= w_inv) begin
                        rem_v  = DIV_REM_W'(shifted - w_inv);
                        quot_v = {quot_v[DIV_QUOT_W-2:0], 1'b1};
                    end else begin
                        rem_v  = shifted[DIV_REM_W-1:0];
                        quot_v = {quot_v[DIV_QUOT_W-2:0], 1'b0};
                    end
                end
            end
            n_rem[g]  = rem_v;
            n_quot[g] = quot_v;
            n_bits[g] = bits_v;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_hold[g] <= s_hold;
            r_rem[g]  <= n_rem[g];
            r_quot[g] <= n_quot[g];
            r_bits[g] <= n_bits[g];
        end
    end

    assign o_beat.valid = r_valid[DIV_STAGES-1];
    assign o_beat.hold  = r_hold[DIV_STAGES-1];
    assign o_beat.quot  = r_quot[DIV_STAGES-1];

endmodule

>>> src/asg_cos_interp.sv
// phase fold, quarter-wave cosine table lookup with interpolation, raised-cosine value
module asg_cos_interp import asg_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_beat i_beat,
    output t_cos_beat o_beat
);

    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W  = 31 + DEPTH_W;
    localparam int BANK_N  = (SINE_TABLE_DEPTH + 1) / 2 + 1;
    localparam int BANK_W  = $clog2(BANK_N);

    localparam logic [DIV_QUOT_W-1:0] S_Q30  = 33'h0_4000_0000;
    localparam logic [DIV_QUOT_W-1:0] S_Q31  = 33'h0_8000_0000;
    localparam logic [DIV_QUOT_W-1:0] S_3Q30 = 33'h0_C000_0000;
    localparam logic [DIV_QUOT_W-1:0] S_Q32  = 33'h1_0000_0000;

    // table split into even and odd points so each bank is read once per beat
    logic [VALUE_W-1:0] w_even_rom [BANK_N];
    logic [VALUE_W-1:0] w_odd_rom  [BANK_N];

    for (genvar k = 0; k < BANK_N; k++) begin : g_rom
        localparam int          IE = 2 * k;
        localparam int          IO = 2 * k + 1;
        localparam logic [63:0] XE = (PI_HALF_Q30 * 64'(IE)) / SINE_TABLE_DEPTH;
        localparam logic [63:0] XO = (PI_HALF_Q30 * 64'(IO)) / SINE_TABLE_DEPTH;
        assign w_even_rom[k] = cos_rom_entry(IE, SINE_TABLE_DEPTH, XE);
        assign w_odd_rom[k]  = cos_rom_entry(IO, SINE_TABLE_DEPTH, XO);
    end

    // fold stage
    logic        r_fold_valid, r_fold_hold, r_fold_upper;
    logic [30:0] r_u;
    logic        n_upper;
    logic [30:0] n_u;

    always_comb begin
        if (i_beat.hold) begin
            n_u     = '0;
            n_upper = 1'b0;
        end else if (i_beat.quot <= S_Q30) begin
            n_u     = 31'(i_beat.quot);
            n_upper = 1'b0;
        end else if (i_beat.quot <= S_Q31) begin
            n_u     = 31'(S_Q31 - i_beat.quot);
            n_upper = 1'b1;
        end else if (i_beat.quot < S_3Q30) begin
            n_u     = 31'(i_beat.quot - S_Q31);
            n_upper = 1'b1;
        end else begin
            n_u     = 31'(S_Q32 - i_beat.quot);
            n_upper = 1'b0;
        end
    end

    // index stage
    logic [PROD_W-1:0]  w_prod;
    logic               r_mul_valid, r_mul_hold, r_mul_upper;
    logic [DEPTH_W-1:0] r_idx;
    logic [FRAC_W-1:0]  r_mul_frac;

    assign w_prod = PROD_W'(r_u) * PROD_W'(SINE_TABLE_DEPTH);

    // table stage
    logic [BANK_W-1:0]  w_even_addr, w_odd_addr;
    logic [VALUE_W-1:0] n_a, n_b;
    logic               r_rom_valid, r_rom_hold, r_rom_upper;
    logic [VALUE_W-1:0] r_a, r_b;
    logic [FRAC_W-1:0]  r_rom_frac;

    assign w_odd_addr  = BANK_W'(r_idx >> 1);
    assign w_even_addr = BANK_W'(r_idx >> 1) + BANK_W'(r_idx[0]);

    always_comb begin
        if (r_idx[0]) begin
            n_a = w_odd_rom[w_odd_addr];
            n_b = w_even_rom[w_even_addr];
        end else begin
            n_a = w_even_rom[w_even_addr];
            n_b = w_odd_rom[w_odd_addr];
        end
    end

    // interpolation multiply stage
    logic [VALUE_W-1:0]   w_diff;
    logic [VALUE_W+15:0]  w_ip;
    logic                 r_ip_valid, r_ip_hold, r_ip_upper;
    logic [VALUE_W-1:0]   r_ip_a, r_ip_sh;

    assign w_diff = (r_a >= r_b) ? (r_a - r_b) : '0;
    assign w_ip   = (VALUE_W + 16)'(w_diff) * (VALUE_W + 16)'(r_rom_frac);

    // value stage
    logic [VALUE_W-1:0] w_c;
    logic [15:0]        w_half;
    logic [VALUE_W-1:0] n_level_v;
    logic               r_lvl_valid, r_lvl_hold;
    logic [VALUE_W-1:0] r_level_v;

    assign w_c       = r_ip_a - r_ip_sh;
    assign w_half    = 16'((ONE_Q16 - w_c) >> 1);
    assign n_level_v = r_ip_upper ? (ONE_Q16 - {1'b0, w_half}) : {1'b0, w_half};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
            r_mul_valid  <= 1'b0;
            r_rom_valid  <= 1'b0;
            r_ip_valid   <= 1'b0;
            r_lvl_valid  <= 1'b0;
        end else begin
            r_fold_valid <= i_beat.valid;
            r_mul_valid  <= r_fold_valid;
            r_rom_valid  <= r_mul_valid;
            r_ip_valid   <= r_rom_valid;
            r_lvl_valid  <= r_ip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fold_hold  <= i_beat.hold;
        r_fold_upper <= n_upper;
        r_u          <= n_u;

        r_mul_hold   <= r_fold_hold;
        r_mul_upper  <= r_fold_upper;
        r_idx        <= w_prod[30 +: DEPTH_W];
        r_mul_frac   <= w_prod[29:14];

        r_rom_hold   <= r_mul_hold;
        r_rom_upper  <= r_mul_upper;
        r_a          <= n_a;
        r_b          <= n_b;
        r_rom_frac   <= r_mul_frac;

        r_ip_hold    <= r_rom_hold;
        r_ip_upper   <= r_rom_upper;
        r_ip_a       <= r_a;
        r_ip_sh      <= w_ip[VALUE_W+15:16];

        r_lvl_hold   <= r_ip_hold;
        r_level_v    <= n_level_v;
    end

    assign o_beat.valid   = r_lvl_valid;
    assign o_beat.hold    = r_lvl_hold;
    assign o_beat.level_v = r_level_v;

endmodule

>>> src/asymmetric_sine_wave_generator.sv
// top level of the asymmetric sine generator: phase, divider, cosine and level mapping
// an accepted start passes the phase register, divider, cosine and map stages to o_done
// throughput: one time value per cycle, busy stays low; the divider pipeline sets the depth
// the divider resolves 4 quotient bits per stage over 33 bits, 1 in the last stage
// reset is synchronous and active low: clears all valid bits, registers return to defaults
// results are strobed for one cycle on o_done; the receiver cannot stall
module asymmetric_sine_wave_generator import asg_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [TIME_W-1:0]         i_time_value,
    output logic                      o_done,
    output logic signed [LEVEL_W-1:0] o_wave_level,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    t_cfg      w_cfg;
    t_div_beat w_div;
    t_cos_beat w_cos;

    asg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy = 1'b0;

    // phase stage
    logic [PHASE_W-1:0] w_phase;
    logic               r_phase_valid;
    logic [PHASE_W-1:0] r_phase;

    assign w_phase = i_time_value * PHASE_W'(w_cfg.frequency)
                   + {w_cfg.offset_phase, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_valid <= 1'b0;
        end else begin
            r_phase_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= w_phase;
    end

    asg_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_phase_valid),
        .i_phase     (r_phase),
        .i_asymmetry (w_cfg.asymmetry),
        .o_beat      (w_div)
    );

    asg_cos_interp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_cos_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_div),
        .o_beat  (w_cos)
    );

    // level mapping
    logic signed [LEVEL_W:0]    w_span;
    logic signed [34:0]         w_map_prod;
    logic                       r_map_valid, r_map_hold;
    logic signed [34:0]         r_map_prod;
    logic signed [35:0]         w_rounded;
    logic signed [19:0]         w_quot;
    logic signed [20:0]         w_sum;
    logic signed [LEVEL_W-1:0]  n_wave_level;
    logic                       r_done;
    logic signed [LEVEL_W-1:0]  r_wave_level;

    assign w_span     = (LEVEL_W + 1)'(w_cfg.max_level) - (LEVEL_W + 1)'(w_cfg.min_level);
    assign w_map_prod = 35'(w_span) * 35'($signed({1'b0, w_cos.level_v}));

    assign w_rounded = 36'(r_map_prod) + 36'sd32768;
    assign w_quot    = $signed(w_rounded[35:16]);
    assign w_sum     = 21'(w_cfg.min_level) + 21'(w_quot);

    always_comb begin
        if (r_map_hold) begin
            n_wave_level = w_cfg.min_level;
        end else if (w_sum > 21'sd32767) begin
            n_wave_level = 16'sh7FFF;
        end else if (w_sum < -21'sd32768) begin
            n_wave_level = 16'sh8000;
        end else begin
            n_wave_level = w_sum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_map_valid <= w_cos.valid;
            r_done      <= r_map_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_map_hold   <= w_cos.hold;
        r_map_prod   <= w_map_prod;
        r_wave_level <= n_wave_level;
    end

    assign o_done       = r_done;
    assign o_wave_level = r_wave_level;

    a_level_v_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cos.valid |-> w_cos.level_v <= ONE_Q16)
        else $error("raised cosine value above one");

    a_map_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map_valid |=> o_done)
        else $error("mapped beat did not reach the output");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_map_valid |=> !o_done)
        else $error("output strobe without a beat in flight");

    a_hold_gives_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_map_valid && r_map_hold) |=> o_wave_level == $past(w_cfg.min_level))
        else $error("held phase did not give the minimum level");

endmodule

>>> test/tb_asymmetric_sine_wave_generator.sv
// testbench for the asymmetric sine wave generator checked against a local wave predictor
module tb_asymmetric_sine_wave_generator;
    import asg_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_FIRST  = 200;
    localparam int QUIET_LAST   = 300;
    localparam int DRAIN_EVERY  = 240;
    localparam int DRAIN_AT     = 120;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_ITEMS   = 55;

    typedef struct {
        logic [TIME_W-1:0]         tv;
        logic signed [LEVEL_W-1:0] level;
    } t_wave_expect;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [TIME_W-1:0]         i_time_value = '0;
    logic                      o_done;
    logic signed [LEVEL_W-1:0] o_wave_level;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    logic [FREQ_W-1:0]         freq_m = FREQUENCY_RESET;
    logic [FRAC_W-1:0]         offset_m = '0;
    logic [FRAC_W-1:0]         asym_m = '0;
    logic signed [LEVEL_W-1:0] lo_m = '0;
    logic signed [LEVEL_W-1:0] hi_m = MAX_LEVEL_RESET;

    logic [VALUE_W-1:0] cos_tab [0:TABLE_DEPTH];
    logic [TIME_W-1:0]  time_values_pending[$];
    t_wave_expect       expected_levels[$];
    int                 n_sent = 0;
    int                 err_cnt = 0;
    int                 cycle_cnt = 0;
    logic               draining = 1'b0;

    asymmetric_sine_wave_generator #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_time_value (i_time_value),
        .o_done       (o_done),
        .o_wave_level (o_wave_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // quarter-wave cosine point in Q1.16 by a truncating series in Q2.30
    function automatic logic [VALUE_W-1:0] cos_point(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = (PI_HALF_Q30 * 64'(i)) / 64'(TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = $signed(term);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        return VALUE_W'(($unsigned(acc) + 64'd8192) >> 14);
    endfunction

    // interpolated cosine, u in Q1.30 quarter periods
    function automatic logic [VALUE_W-1:0] cos_at(input logic [63:0] u);
        logic [63:0]        p;
        logic [63:0]        idx;
        logic [63:0]        f;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] c;
        p   = u * 64'(TABLE_DEPTH);
        idx = p >> 30;
        f   = (p >> 14) & 64'hFFFF;
        if (idx >= 64'(TABLE_DEPTH)) begin
            c = cos_tab[TABLE_DEPTH];
        end else begin
            a = cos_tab[idx];
            b = cos_tab[idx + 1];
            if (b > a) begin
                b = a;
            end
            c = a - VALUE_W'((64'(a - b) * f) >> 16);
        end
        return c;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] wave_level_of(input logic [TIME_W-1:0] tv);
        logic [31:0]        ph;
        logic [63:0]        inv;
        logic [63:0]        s;
        logic [63:0]        vv;
        logic signed [63:0] span;
        logic signed [63:0] lvl;
        ph  = 32'(64'(tv) * 64'(freq_m) + (64'(offset_m) << 16));
        inv = 64'd65536 - 64'(asym_m);
        if (64'(ph) > (inv << 16)) begin
            lvl = lo_m;
        end else begin
            s = (64'(ph) << 16) / inv;
            if (s > 64'h8000_0000) begin
                s = 64'h1_0000_0000 - s;
            end
            if (s <= 64'h4000_0000) begin
                vv = (64'd65536 - 64'(cos_at(s))) >> 1;
            end else begin
                vv = 64'd65536 - ((64'd65536 - 64'(cos_at(64'h8000_0000 - s))) >> 1);
            end
            span = hi_m - lo_m;
            lvl  = lo_m + ((span * $signed(vv) + 64'sd32768) >>> 16);
        end
        if (lvl > 64'sd32767) begin
            lvl = 64'sd32767;
        end
        if (lvl < -64'sd32768) begin
            lvl = -64'sd32768;
        end
        return lvl[LEVEL_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FREQUENCY:    freq_m   = data[FREQ_W-1:0];
            REG_OFFSET_PHASE: offset_m = data[FRAC_W-1:0];
            REG_ASYMMETRY:    asym_m   = data[FRAC_W-1:0];
            REG_MIN_LEVEL:    lo_m     = data[LEVEL_W-1:0];
            REG_MAX_LEVEL:    hi_m     = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (time_values_pending.size() != 0 || expected_levels.size() != 0 || start);
    endtask

    function automatic logic [LEVEL_W-1:0] random_level();
        logic [LEVEL_W-1:0] lv;
        case ($urandom_range(0, 3))
            0: lv = 16'h8000;
            1: lv = 16'h7FFF;
            default: lv = LEVEL_W'($urandom);
        endcase
        return lv;
    endfunction

    task automatic random_settings();
        logic [FREQ_W-1:0] fr;
        logic [FRAC_W-1:0] asy;
        case ($urandom_range(0, 4))
            0: fr = FREQ_W'($urandom_range(1, 24'hFFFFFF));
            1: fr = ($urandom_range(0, 1) == 0) ? 24'd1 : 24'hFFFFFF;
            2: fr = FREQ_W'($urandom_range(1024, 262144));
            3: fr = FREQUENCY_RESET;
            default: fr = FREQ_W'($urandom_range(1, 24'hFFFFFF));
        endcase
        case ($urandom_range(0, 4))
            0: asy = '0;
            1: asy = 16'hFFFF;
            2: asy = FRAC_W'($urandom_range(0, 32768));
            default: asy = FRAC_W'($urandom);
        endcase
        cfg_write(REG_FREQUENCY, APB_DATA_W'(fr));
        cfg_write(REG_OFFSET_PHASE, $urandom);
        cfg_write(REG_ASYMMETRY, APB_DATA_W'(asy));
        cfg_write(REG_MIN_LEVEL, {16'(~$urandom), random_level()});
        cfg_write(REG_MAX_LEVEL, {16'($urandom), random_level()});
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        logic [TIME_W-1:0] tv;
        case ($urandom_range(0, 3))
            0: tv = TIME_W'($urandom_range(0, 32'h3FFFF));
            1: tv = ($urandom & 32'hFFFF_0000) | TIME_W'($urandom_range(0, 3) * 32'h4000);
            default: tv = $urandom;
        endcase
        return tv;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic              nxt_start;
        logic [TIME_W-1:0] nxt_time;
        logic              quiet;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_time_value <= '0;
        end else begin
            if (start && !busy) begin
                expected_levels.push_back('{i_time_value, wave_level_of(i_time_value)});
                time_values_pending.delete(0);
                n_sent++;
                if (n_sent % DRAIN_EVERY == DRAIN_AT) begin
                    draining = 1'b1;
                end
            end
            if (draining && expected_levels.size() == 0) begin
                draining = 1'b0;
            end
            quiet     = (n_sent >= QUIET_FIRST && n_sent < QUIET_LAST);
            nxt_start = 1'b0;
            nxt_time  = i_time_value;
            if (start && busy) begin
                nxt_start = 1'b1;
            end else if (!draining && time_values_pending.size() != 0
                         && (quiet || $urandom_range(0, 99) >= 20)) begin
                nxt_start = 1'b1;
                nxt_time  = time_values_pending[0];
            end
            start        <= nxt_start;
            i_time_value <= nxt_time;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_wave_expect want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, wave_level %0d", o_wave_level));
            end else begin
                want = expected_levels.pop_front();
                if (o_done !== 1'b1 || o_wave_level !== want.level) begin
                    report_mismatch($sformatf("time %08h: wave_level got %0d expected %0d",
                                              want.tv, o_wave_level, want.level));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            cos_tab[i] = cos_point(i);
        end
        cos_tab[0]           = ONE_Q16;
        cos_tab[TABLE_DEPTH] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, one wave period every 0x10000 time units
        @(negedge i_clk);
        time_values_pending.push_back(32'h0000_0000);
        time_values_pending.push_back(32'h0000_4000);
        time_values_pending.push_back(32'h0000_8000);
        time_values_pending.push_back(32'h0000_C000);
        time_values_pending.push_back(32'h0000_FFFF);
        time_values_pending.push_back(32'h0001_0000);
        time_values_pending.push_back(32'hFFFF_FFFF);
        time_values_pending.push_back(32'hAAAA_AAAA);
        time_values_pending.push_back(32'h5555_5555);
        wait_idle();

        // top extremes, nearly all of the period held at min, full span
        cfg_write(REG_FREQUENCY, 32'h00FF_FFFF);
        cfg_write(REG_OFFSET_PHASE, 32'h0000_FFFF);
        cfg_write(REG_ASYMMETRY, 32'h0000_FFFF);
        cfg_write(REG_MIN_LEVEL, 32'h0000_8000);
        cfg_write(REG_MAX_LEVEL, 32'h0000_7FFF);
        @(negedge i_clk);
        time_values_pending.push_back(32'h0000_0000);
        time_values_pending.push_back(32'h0000_0001);
        time_values_pending.push_back(32'hFFFF_FFFF);
        time_values_pending.push_back(32'h8000_0000);
        time_values_pending.push_back(32'h1234_5678);
        wait_idle();

        // slowest wave, half held, min above max, unused addresses ignored
        cfg_write(REG_FREQUENCY, 32'h0000_0001);
        cfg_write(REG_OFFSET_PHASE, 32'h0000_8000);
        cfg_write(REG_ASYMMETRY, 32'h0000_8000);
        cfg_write(REG_MIN_LEVEL, 32'h0000_7FFF);
        cfg_write(REG_MAX_LEVEL, 32'hFFFF_8000);
        for (int r = int'(REG_MAX_LEVEL) + 1; r < 2 ** CFG_IDX_W; r++) begin
            cfg_write(CFG_IDX_W'(r), $urandom);
        end
        @(negedge i_clk);
        time_values_pending.push_back(32'h0000_0000);
        time_values_pending.push_back(32'h0001_0000);
        time_values_pending.push_back(32'hFFFF_FFFF);
        time_values_pending.push_back(32'h0000_8000);
        time_values_pending.push_back(32'h4000_0000);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_settings();
            @(negedge i_clk);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                time_values_pending.push_back(random_time());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_levels.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
